### src/hsdc_pkg.sv
`timescale 1ns / 1ps
// Package with shared types and constants for the humidity sensor defog control core.
package hsdc_pkg;

	localparam int CFG_DATA_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int LEVEL_WIDTH = 14;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NOT_INIT     = 3'd1,
		ST_DISCONNECTED = 3'd2,
		ST_BAD_READING  = 3'd3,
		ST_OUT_OF_RANGE = 3'd4
	} status_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_SENSOR_READY     = 3'd0,
		REG_SENSOR_HEALTHY   = 3'd1,
		REG_SATURATION_LEVEL = 3'd2,
		REG_RELEASE_LEVEL    = 3'd3,
		REG_SATURATION_TIME  = 3'd4,
		REG_HEAT_TIME        = 3'd5,
		REG_COOLDOWN_TIME    = 3'd6
	} reg_index_t;

	localparam logic [LEVEL_WIDTH-1:0] SATURATION_LEVEL_RST = 14'd9900;
	localparam logic [LEVEL_WIDTH-1:0] RELEASE_LEVEL_RST = 14'd9000;
	localparam logic [31:0] SATURATION_TIME_RST = 32'd600000;
	localparam logic [31:0] HEAT_TIME_RST = 32'd300000;
	localparam logic [31:0] COOLDOWN_TIME_RST = 32'd30000;

	localparam logic signed [15:0] TEMP_MIN = -16'sd4000;
	localparam logic signed [15:0] TEMP_MAX = 16'sd12500;
	localparam logic signed [15:0] HUM_MIN = 16'sd0;
	localparam logic signed [15:0] HUM_MAX = 16'sd10000;

endpackage

### src/humidity_sensor_defog_control_core.sv
`timescale 1ns / 1ps
// Humidity sensor defog control core: reading check, saturation timing, heater and defog flags.
// A transaction is captured in the input register, then its result in the output register.
// One transaction per cycle while out_stall is low; the input register feeds one compare stage.
// The output register lets a new transaction enter while a result waits under stall.
// Reset clears valids, heater and saturation state, and loads register defaults.
// Status, heater and hold timing all follow from one pass over the registered reading.
module humidity_sensor_defog_control_core #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [hsdc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [hsdc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [31:0]                             now_ms,
	input  logic signed [15:0]                      temp_centi,
	input  logic signed [15:0]                      hum_centi,
	input  logic                                    reading_ok,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output hsdc_pkg::status_t                       status,
	output logic signed [14:0]                      temp_out,
	output logic                                    temp_blanked,
	output logic [13:0]                             hum_out,
	output logic                                    heater_on,
	output logic                                    defogging
);
	import hsdc_pkg::*;

	localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	logic                   sensor_ready_q;
	logic                   sensor_healthy_q;
	logic [LEVEL_WIDTH-1:0] saturation_level_q;
	logic [LEVEL_WIDTH-1:0] release_level_q;
	logic [31:0]            saturation_time_q;
	logic [31:0]            heat_time_q;
	logic [31:0]            cooldown_time_q;

	logic                   heater_active_q;
	logic                   saturation_tracking_q;
	logic [TIME_WIDTH-1:0]  saturation_start_q;
	logic [TIME_WIDTH-1:0]  heat_start_q;
	logic [TIME_WIDTH-1:0]  hold_until_q;

	logic                   valid_s1;
	logic [31:0]            now_s1;
	logic signed [15:0]     temp_s1;
	logic signed [15:0]     hum_s1;
	logic                   ok_s1;

	logic                   out_valid_q;
	logic                   advance;

	logic [CW-1:0]          now_cw;
	logic [TIME_WIDTH-1:0]  now_t;
	logic [TIME_WIDTH-1:0]  sat_diff;
	logic [TIME_WIDTH-1:0]  heat_diff;
	logic [CW-1:0]          hold_sum;
	logic                   hum_saturated;
	logic                   hum_released;
	logic                   sat_expired;
	logic                   heat_expired;
	logic                   temp_bad;
	logic                   hum_bad;

	status_t                status_d;
	logic                   blanked_d;
	logic signed [14:0]     temp_d;
	logic [13:0]            hum_d;
	logic                   heater_d;
	logic                   tracking_d;
	logic [TIME_WIDTH-1:0]  sat_start_d;
	logic [TIME_WIDTH-1:0]  heat_start_d;
	logic [TIME_WIDTH-1:0]  hold_until_d;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign out_valid = out_valid_q;

	assign now_cw = CW'(now_s1);
	assign now_t = now_cw[TIME_WIDTH-1:0];
	assign sat_diff = now_t - saturation_start_q;
	assign heat_diff = now_t - heat_start_q;
	assign hold_sum = now_cw + CW'(cooldown_time_q);
	assign hum_saturated = hum_s1 >= $signed({2'b00, saturation_level_q});
	assign hum_released = hum_s1 < $signed({2'b00, release_level_q});
	assign sat_expired = CW'(sat_diff) > CW'(saturation_time_q);
	assign heat_expired = CW'(heat_diff) > CW'(heat_time_q);
	assign temp_bad = (temp_s1 < TEMP_MIN) || (temp_s1 > TEMP_MAX);
	assign hum_bad = (hum_s1 < HUM_MIN) || (hum_s1 > HUM_MAX);

	always_comb begin
		status_d = ST_OK;
		blanked_d = 1'b0;
		temp_d = '0;
		hum_d = '0;
		heater_d = heater_active_q;
		tracking_d = saturation_tracking_q;
		sat_start_d = saturation_start_q;
		heat_start_d = heat_start_q;
		hold_until_d = hold_until_q;
		if (!sensor_ready_q) begin
			status_d = ST_NOT_INIT;
		end else if (!sensor_healthy_q) begin
			status_d = ST_DISCONNECTED;
		end else if (!ok_s1) begin
			status_d = ST_BAD_READING;
		end else begin
			if (!heater_active_q) begin
				if (hum_saturated) begin
					if (!saturation_tracking_q) begin
						tracking_d = 1'b1;
						sat_start_d = now_t;
					end else if (sat_expired) begin
						heater_d = 1'b1;
						heat_start_d = now_t;
						hold_until_d = hold_sum[TIME_WIDTH-1:0];
					end
				end else begin
					tracking_d = 1'b0;
				end
			end else begin
				blanked_d = 1'b1;
				hold_until_d = hold_sum[TIME_WIDTH-1:0];
				if (heat_expired || hum_released) begin
					heater_d = 1'b0;
					tracking_d = 1'b0;
				end
			end
			if ((!blanked_d && temp_bad) || hum_bad) begin
				status_d = ST_OUT_OF_RANGE;
				blanked_d = 1'b0;
			end else begin
				temp_d = blanked_d ? '0 : temp_s1[14:0];
				hum_d = hum_s1[13:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_ready_q <= 1'b0;
			sensor_healthy_q <= 1'b1;
			saturation_level_q <= SATURATION_LEVEL_RST;
			release_level_q <= RELEASE_LEVEL_RST;
			saturation_time_q <= SATURATION_TIME_RST;
			heat_time_q <= HEAT_TIME_RST;
			cooldown_time_q <= COOLDOWN_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSOR_READY: begin
					sensor_ready_q <= cfg_data[0];
				end
				REG_SENSOR_HEALTHY: begin
					sensor_healthy_q <= cfg_data[0];
				end
				REG_SATURATION_LEVEL: begin
					saturation_level_q <= cfg_data[LEVEL_WIDTH-1:0];
				end
				REG_RELEASE_LEVEL: begin
					release_level_q <= cfg_data[LEVEL_WIDTH-1:0];
				end
				REG_SATURATION_TIME: begin
					saturation_time_q <= cfg_data;
				end
				REG_HEAT_TIME: begin
					heat_time_q <= cfg_data;
				end
				REG_COOLDOWN_TIME: begin
					cooldown_time_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			heater_active_q <= 1'b0;
			saturation_tracking_q <= 1'b0;
			saturation_start_q <= '0;
			heat_start_q <= '0;
			hold_until_q <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				heater_active_q <= heater_d;
				saturation_tracking_q <= tracking_d;
				saturation_start_q <= sat_start_d;
				heat_start_q <= heat_start_d;
				hold_until_q <= hold_until_d;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1 <= now_ms;
			temp_s1 <= temp_centi;
			hum_s1 <= hum_centi;
			ok_s1 <= reading_ok;
		end
		if (advance) begin
			status <= status_d;
			temp_out <= temp_d;
			temp_blanked <= blanked_d;
			hum_out <= hum_d;
			heater_on <= heater_d;
			defogging <= heater_d || (now_t < hold_until_d);
		end
	end

endmodule
